@@ sv/sscx_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sscx_pkg
// shared sizes, controller state codes and controller/datapath bundles for
// the stripe segment center extractor
// ----------------------------------------------------------------------------
package sscx_pkg;

  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_WIDTH  = 2048;

  localparam int PIX_W = 8;
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int SUM_W = PIX_W + ROW_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_PUSH = 4'b1000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic idle;
    logic accept;
    logic cmp;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic finish;
    logic need_search;
    logic cmp_done;
    logic out_free;
    logic run_active;
  } status_t;

endpackage
`default_nettype wire

@@ sv/stripe_segment_center_extractor.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stripe_segment_center_extractor
// finds bright runs in column-ordered pixels and reports one point per run:
// column, half-sum row and peak brightness
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i/in_stall_o  | pixel, last_in_column,
//          |           |                        | last_in_frame
//  out     | output    | out_valid_o/out_stall_i| column, row, peak_value
//  cfg     | input     | cfg_we_i               | pixel threshold (cfg_wdata_i)
//
//  a pixel that closes no run leaves the sequencer idle, so back to back
//  pixels stream; a pixel that closes a single-row run goes straight to the
//  push, one that closes a longer run first runs the read and compare states;
//  the search compares one prefix ram word per cycle
//  the result sits in an output register; input is taken again once the
//  result has moved there, even while out_stall_i holds it; a point still
//  held there stretches the push of the next one
//  reset clears counters, the run flag and the limit; the prefix ram needs no
//  clearing, every row read was written earlier in the same run
// ----------------------------------------------------------------------------
module stripe_segment_center_extractor (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [sscx_pkg::PIX_W-1:0]  cfg_wdata_i,
  // pixel transactions
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [sscx_pkg::PIX_W-1:0]  pixel_i,
  input  wire logic                        last_in_column_i,
  input  wire logic                        last_in_frame_i,
  // point transactions
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [sscx_pkg::COL_W-1:0]  column_o,
  output      logic [sscx_pkg::ROW_W-1:0]  row_o,
  output      logic [sscx_pkg::PIX_W-1:0]  peak_value_o
);
  import sscx_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // controller: pixel intake, search sequencing, result push
  sscx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: run state, prefix ram, search pointer, output register
  sscx_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .pixel_i          (pixel_i),
    .last_in_column_i (last_in_column_i),
    .last_in_frame_i  (last_in_frame_i),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .column_o         (column_o),
    .row_o            (row_o),
    .peak_value_o     (peak_value_o)
  );

  // pixels are taken only while the sequencer is idle
  assign in_stall_o = !cmd.idle;

  // a pushed point always carries a nonzero peak
  a_push_peak : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> (out_valid_o && (peak_value_o != '0)))
    else $error("pushed point without valid nonzero peak");

  // a run-closing pixel always leaves idle to produce its point
  a_finish_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && sts.finish) |=> !cmd.idle)
    else $error("run end did not start result sequence");

  // the run is closed for the whole search and push
  a_run_closed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd.idle |-> !sts.run_active)
    else $error("run still open while producing a point");

endmodule
`default_nettype wire

@@ sv/sscx_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sscx_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sscx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ sv/sscx_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sscx_ctrl
// sequencer: pixel intake, half-sum search over the prefix ram, result push
// ----------------------------------------------------------------------------
module sscx_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire sscx_pkg::status_t sts_i,
  output      sscx_pkg::cmd_t    cmd_o
);
  import sscx_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    cmd_o          = '0;
    cmd_o.idle     = (state_q == S_IDLE);
    cmd_o.accept   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.cmp      = (state_q == S_CMP);
    cmd_o.load_out = (state_q == S_PUSH) && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && sts_i.finish) begin
          state_d = sts_i.need_search ? S_READ : S_PUSH;
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (sts_i.cmp_done) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/sscx_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sscx_dp
// run tracking, prefix sum ram, half-sum search pointer and output register
// ----------------------------------------------------------------------------
module sscx_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [sscx_pkg::PIX_W-1:0]  cfg_wdata_i,
  input  wire logic [sscx_pkg::PIX_W-1:0]  pixel_i,
  input  wire logic                        last_in_column_i,
  input  wire logic                        last_in_frame_i,
  input  wire logic                        out_stall_i,
  input  wire sscx_pkg::cmd_t              cmd_i,
  output      sscx_pkg::status_t           sts_o,
  output      logic                        out_valid_o,
  output      logic [sscx_pkg::COL_W-1:0]  column_o,
  output      logic [sscx_pkg::ROW_W-1:0]  row_o,
  output      logic [sscx_pkg::PIX_W-1:0]  peak_value_o
);
  import sscx_pkg::*;

  // control state
  logic [PIX_W-1:0] limit_q;
  logic             run_active_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             out_valid_q;

  // payload
  logic [ROW_W-1:0] run_start_q;
  logic [SUM_W-1:0] run_sum_q;
  logic [PIX_W-1:0] run_peak_q;
  logic [ROW_W-1:0] r_q;
  logic [ROW_W-1:0] last_q;
  logic [COL_W-1:0] res_col_q;
  logic [COL_W-1:0] out_col_q;
  logic [ROW_W-1:0] out_row_q;
  logic [PIX_W-1:0] out_peak_q;

  logic             bright;
  logic             col_end;
  logic [SUM_W-1:0] new_sum;
  logic [ROW_W-1:0] new_start;
  logic [PIX_W-1:0] peak_base;
  logic [PIX_W-1:0] new_peak;
  logic [ROW_W-1:0] last_row;
  logic [ROW_W-1:0] r_nx;
  logic [SUM_W-1:0] half;
  logic [SUM_W-1:0] rd_data;
  logic [ROW_W-1:0] rd_addr;
  logic             below_half;
  logic             out_free;

  assign bright    = pixel_i > limit_q;
  assign col_end   = last_in_column_i || last_in_frame_i ||
                     (row_q == ROW_W'(MAX_HEIGHT - 1));
  assign new_sum   = (run_active_q ? run_sum_q : '0) + SUM_W'(pixel_i);
  assign new_start = run_active_q ? run_start_q : row_q;
  assign peak_base = run_active_q ? run_peak_q : '0;
  assign new_peak  = (pixel_i > peak_base) ? pixel_i : peak_base;
  // a dark pixel closes the run on the row above
  assign last_row  = bright ? row_q : row_q - 1'b1;
  assign r_nx      = r_q + 1'b1;
  assign half      = run_sum_q >> 1;
  assign below_half = rd_data < half;
  assign out_free  = !out_valid_q || !out_stall_i;

  // speculative read of the next row while comparing the current one
  assign rd_addr = cmd_i.cmp ? r_nx : r_q;

  always_comb begin
    sts_o             = '0;
    sts_o.finish      = bright ? col_end : run_active_q;
    sts_o.need_search = new_start < last_row;
    sts_o.cmp_done    = !below_half || (r_nx >= last_q);
    sts_o.out_free    = out_free;
    sts_o.run_active  = run_active_q;
  end

  sscx_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_HEIGHT)
  ) u_prefix_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && bright),
    .waddr_i (row_q),
    .wdata_i (new_sum),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      <= '0;
      run_active_q <= 1'b0;
      row_q        <= '0;
      col_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        run_active_q <= bright && !col_end;
        if (col_end) begin
          row_q <= '0;
          if (last_in_frame_i || (col_q == COL_W'(MAX_WIDTH - 1))) begin
            col_q <= '0;
          end else begin
            col_q <= col_q + 1'b1;
          end
        end else begin
          row_q <= row_q + 1'b1;
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && bright) begin
      run_start_q <= new_start;
      run_sum_q   <= new_sum;
      run_peak_q  <= new_peak;
    end
    if (cmd_i.accept && sts_o.finish) begin
      r_q       <= new_start;
      last_q    <= last_row;
      res_col_q <= col_q;
    end else if (cmd_i.cmp && below_half) begin
      r_q <= r_nx;
    end
    if (cmd_i.load_out) begin
      out_col_q  <= res_col_q;
      out_row_q  <= r_q;
      out_peak_q <= run_peak_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign column_o     = out_col_q;
  assign row_o        = out_row_q;
  assign peak_value_o = out_peak_q;

endmodule
`default_nettype wire
